// ===== hdl/srlt_pkg.sv =====
`default_nettype none

package srlt_pkg;

  localparam int unsigned TableDepthDef = 128;
  localparam int unsigned TimeBitsDef   = 48;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned ThreshW = 32;
  localparam int unsigned IndexW  = 7;

  localparam logic [ThreshW-1:0] ThreshReset = 32'd500000;
  localparam logic [31:0]        V4Loopback  = 32'h7F00_0001;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_TOUCH = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LIMIT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/source_rate_limit_table_unit.sv =====
`default_nettype none

// Per-source rate limit table. An item is taken when start is high and busy is low. Its
// single result is on the result ports for exactly one cycle, marked by result_valid_o, and
// the receiver cannot stall it. The result appears in the first cycle after the item is done:
// the cycle after the accepting edge for an item that needs no scan, or the first cycle with
// busy low again after a scan. An add, an unused mode, or a touch or query on an empty table
// needs no scan. A touch or query scans the stored entries through the single read port of
// the entry memory, one entry per cycle from index 0, and stops at the first match. It keeps
// busy high while entries are examined, and a query hit adds the ST_LIMIT state for the
// threshold compare. The threshold register is written through cfg_valid_i / cfg_data_i and
// should only be written while the block is idle.
module source_rate_limit_table_unit #(
  parameter int unsigned TABLE_DEPTH = srlt_pkg::TableDepthDef,
  parameter int unsigned TIME_BITS   = srlt_pkg::TimeBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   mode_i,
  input  wire logic                         is_ipv6_i,
  input  wire logic [srlt_pkg::AddrW-1:0]   addr_high_i,
  input  wire logic [srlt_pkg::AddrW-1:0]   addr_low_i,
  input  wire logic [TIME_BITS-1:0]         now_time_i,
  input  wire logic                         has_time_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [srlt_pkg::ThreshW-1:0] cfg_data_i,
  output logic                              result_valid_o,
  output logic                              found_o,
  output logic [srlt_pkg::IndexW-1:0]       entry_index_o,
  output logic                              limited_o,
  output logic                              accepted_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned GapW = (TIME_BITS > srlt_pkg::ThreshW) ? TIME_BITS : srlt_pkg::ThreshW;

  typedef struct packed {
    logic                       fam;
    logic [srlt_pkg::AddrW-1:0] hi;
    logic [srlt_pkg::AddrW-1:0] lo;
    logic [TIME_BITS-1:0]       tm;
    logic                       tv;
  } entry_t;

  entry_t entry_mem [TABLE_DEPTH];
  entry_t rd_data_q;
  entry_t wr_data;
  logic   wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;

  srlt_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic [srlt_pkg::ThreshW-1:0] thresh_q;

  srlt_pkg::mode_e            op_q;
  logic                       fam_q;
  logic [srlt_pkg::AddrW-1:0] hi_q;
  logic [srlt_pkg::AddrW-1:0] lo_q;
  logic [TIME_BITS-1:0]       now_q;
  logic [TIME_BITS-1:0]       hit_tm_q;
  logic                       hit_tv_q;

  logic            res_valid_q, res_valid_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            limited_q, limited_d;
  logic            accepted_q, accepted_d;

  logic            accept;
  logic            full;
  logic            last;
  logic            match;
  logic [IdxW-1:0] add_slot;
  logic [IdxW-1:0] scan_inc;
  logic [GapW-1:0] tm_ext, now_ext, gap;
  logic            gap_ok;
  logic [IdxW+srlt_pkg::IndexW-1:0] idx_ext;

  assign accept      = start && (state_q == srlt_pkg::ST_IDLE);
  assign busy        = (state_q != srlt_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign full     = (fill_q == CntW'(TABLE_DEPTH));
  assign add_slot = full ? ptr_q : fill_q[IdxW-1:0];
  assign last     = (({1'b0, scan_q} + CntW'(1)) == fill_q);
  assign scan_inc = scan_q + IdxW'(1);

  // Address match against the entry read in the previous cycle. A loopback address on
  // either side matches any address of the same family.
  always_comb begin
    match = 1'b0;
    if (rd_data_q.fam == fam_q) begin
      if (!fam_q) begin
        match = (rd_data_q.lo[31:0] == lo_q[31:0]) ||
                (rd_data_q.lo[31:0] == srlt_pkg::V4Loopback) ||
                (lo_q[31:0] == srlt_pkg::V4Loopback);
      end else begin
        match = ((rd_data_q.hi == hi_q) && (rd_data_q.lo == lo_q)) ||
                ((rd_data_q.hi == '0) && (rd_data_q.lo == srlt_pkg::AddrW'(1))) ||
                ((hi_q == '0) && (lo_q == srlt_pkg::AddrW'(1)));
      end
    end
  end

  assign tm_ext  = GapW'(hit_tm_q);
  assign now_ext = GapW'(now_q);
  assign gap     = (tm_ext > now_ext) ? (tm_ext - now_ext) : (now_ext - tm_ext);
  assign gap_ok  = (gap <= GapW'(thresh_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srlt_pkg::ST_IDLE: begin
        if (accept && (fill_q != '0) &&
            ((mode_i == srlt_pkg::MODE_TOUCH) || (mode_i == srlt_pkg::MODE_QUERY))) begin
          state_d = srlt_pkg::ST_SCAN;
        end
      end
      srlt_pkg::ST_SCAN: begin
        if (match) begin
          state_d = (op_q == srlt_pkg::MODE_TOUCH) ? srlt_pkg::ST_IDLE : srlt_pkg::ST_LIMIT;
        end else if (last) begin
          state_d = srlt_pkg::ST_IDLE;
        end
      end
      srlt_pkg::ST_LIMIT: begin
        state_d = srlt_pkg::ST_IDLE;
      end
      default: begin
        state_d = srlt_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory access, table bookkeeping and results.
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = add_slot;
    wr_data     = rd_data_q;
    rd_addr     = '0;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    scan_d      = scan_q;
    res_valid_d = 1'b0;
    found_d     = 1'b0;
    idx_d       = '0;
    limited_d   = 1'b0;
    accepted_d  = 1'b0;
    case (state_q)
      srlt_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            srlt_pkg::MODE_ADD: begin
              wr_en      = 1'b1;
              wr_data.fam = is_ipv6_i;
              wr_data.hi  = addr_high_i;
              wr_data.lo  = addr_low_i;
              wr_data.tm  = has_time_i ? now_time_i : '0;
              wr_data.tv  = has_time_i;
              if (full) begin
                ptr_d = (ptr_q == IdxW'(TABLE_DEPTH - 1)) ? '0 : ptr_q + IdxW'(1);
              end else begin
                fill_d = fill_q + CntW'(1);
              end
              res_valid_d = 1'b1;
              accepted_d  = 1'b1;
              idx_d       = add_slot;
            end
            srlt_pkg::MODE_TOUCH, srlt_pkg::MODE_QUERY: begin
              scan_d = '0;
              if (fill_q == '0) begin
                res_valid_d = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      srlt_pkg::ST_SCAN: begin
        rd_addr = last ? '0 : scan_inc;
        if (match) begin
          if (op_q == srlt_pkg::MODE_TOUCH) begin
            wr_en       = 1'b1;
            wr_addr     = scan_q;
            wr_data.tm  = now_q;
            wr_data.tv  = 1'b1;
            res_valid_d = 1'b1;
            found_d     = 1'b1;
            accepted_d  = 1'b1;
            idx_d       = scan_q;
          end
        end else if (last) begin
          res_valid_d = 1'b1;
        end else begin
          scan_d = scan_inc;
        end
      end
      srlt_pkg::ST_LIMIT: begin
        res_valid_d = 1'b1;
        found_d     = 1'b1;
        idx_d       = scan_q;
        limited_d   = hit_tv_q && gap_ok;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srlt_pkg::ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      scan_q      <= '0;
      res_valid_q <= 1'b0;
      thresh_q    <= srlt_pkg::ThreshReset;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      scan_q      <= scan_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= srlt_pkg::mode_e'(mode_i);
      fam_q <= is_ipv6_i;
      hi_q  <= addr_high_i;
      lo_q  <= addr_low_i;
      now_q <= now_time_i;
    end
    if (state_q == srlt_pkg::ST_SCAN) begin
      hit_tm_q <= rd_data_q.tm;
      hit_tv_q <= rd_data_q.tv;
    end
    found_q    <= found_d;
    idx_q      <= idx_d;
    limited_q  <= limited_d;
    accepted_q <= accepted_d;
  end

  assign idx_ext        = {{srlt_pkg::IndexW{1'b0}}, idx_q};
  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign entry_index_o  = idx_ext[srlt_pkg::IndexW-1:0];
  assign limited_o      = limited_q;
  assign accepted_o     = accepted_q;

endmodule

`default_nettype wire

// ===== hdl/srlt_checker.sv =====
`default_nettype none

module srlt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] mode_i,
  input wire logic       result_valid_o,
  input wire logic       found_o,
  input wire logic       limited_o,
  input wire logic       accepted_o
);

  logic taken;
  assign taken = start && !busy;

  // An add always lands in the table and reports in the next cycle.
  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken && (mode_i == srlt_pkg::MODE_ADD) |=>
      result_valid_o && accepted_o && !found_o && !limited_o)
    else $error("add item did not report a stored entry in the next cycle");

  // The unused mode does nothing and answers at once with all fields clear.
  a_rsvd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken && (mode_i == srlt_pkg::MODE_RSVD) |=>
      result_valid_o && !found_o && !limited_o && !accepted_o)
    else $error("unused mode item did not give an empty result");

  // Limiting only comes from a query hit, which never counts as accepted.
  a_limit_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && limited_o |-> found_o && !accepted_o)
    else $error("limited result without a query hit");

  // A result follows an item taken in the previous cycle or a scan that was running.
  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(taken) || $past(busy))
    else $error("result strobe without an item in progress");

endmodule

bind source_rate_limit_table_unit srlt_checker u_srlt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .found_o        (found_o),
  .limited_o      (limited_o),
  .accepted_o     (accepted_o)
);

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import srlt_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned TimeW = TimeBitsDef;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned PhaseItems = 140;

  typedef struct packed {
    mode_e            mode;
    logic             v6;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
    logic [TimeW-1:0] now;
    logic             has_time;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] index;
    logic              limited;
    logic              accepted;
  } verdict_t;

  typedef struct packed {
    logic             v6;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
  } source_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_drv = MODE_ADD;
  logic v6_drv = 1'b0;
  logic [AddrW-1:0] hi_drv = '0;
  logic [AddrW-1:0] lo_drv = '0;
  logic [TimeW-1:0] now_drv = '0;
  logic has_time_drv = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ThreshW-1:0] cfg_data = '0;
  logic result_valid;
  logic found;
  logic [IndexW-1:0] entry_index;
  logic limited;
  logic accepted;

  // Shadow copy of the source table and the threshold register.
  logic             tbl_v6      [Depth];
  logic [AddrW-1:0] tbl_hi      [Depth];
  logic [AddrW-1:0] tbl_lo      [Depth];
  logic [TimeW-1:0] tbl_time    [Depth];
  logic             tbl_time_ok [Depth];
  int unsigned fill_count = 0;
  int unsigned replace_ptr = 0;
  logic [ThreshW-1:0] threshold = ThreshReset;

  verdict_t expected_verdicts[$];
  verdict_t observed;
  verdict_t oldest;
  source_t source_pool[PoolSize];
  logic [TimeW-1:0] clock_now = '0;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned mode_count[4] = '{0, 0, 0, 0};
  int unsigned limited_count = 0;
  int unsigned wrap_count = 0;
  int unsigned cfg_writes = 0;
  int unsigned burst_left = 8;
  int unsigned idle_cycles = 0;

  initial forever #4 clk = ~clk;

  source_rate_limit_table_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_drv),
    .is_ipv6_i      (v6_drv),
    .addr_high_i    (hi_drv),
    .addr_low_i     (lo_drv),
    .now_time_i     (now_drv),
    .has_time_i     (has_time_drv),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .found_o        (found),
    .entry_index_o  (entry_index),
    .limited_o      (limited),
    .accepted_o     (accepted)
  );

  function automatic bit addr_hits(int k, item_t it);
    logic [31:0] stored_v4;
    logic [31:0] key_v4;
    stored_v4 = tbl_lo[k][31:0];
    key_v4 = it.lo[31:0];
    if (tbl_v6[k] != it.v6) return 1'b0;
    if (!it.v6) begin
      return stored_v4 == key_v4 || stored_v4 == V4Loopback || key_v4 == V4Loopback;
    end
    if (tbl_hi[k] == it.hi && tbl_lo[k] == it.lo) return 1'b1;
    if (tbl_hi[k] == '0 && tbl_lo[k] == 64'd1) return 1'b1;
    return it.hi == '0 && it.lo == 64'd1;
  endfunction

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic verdict_t predict_verdict(item_t it);
    verdict_t v;
    int hit;
    int unsigned slot;
    logic [TimeW-1:0] gap;
    v = '0;
    hit = -1;
    if (it.mode == MODE_TOUCH || it.mode == MODE_QUERY) begin
      for (int k = 0; k < fill_count; k++) begin
        if (hit < 0 && addr_hits(k, it)) hit = k;
      end
    end
    case (it.mode)
      MODE_ADD: begin
        if (fill_count < Depth) begin
          slot = fill_count;
          fill_count++;
        end else begin
          slot = replace_ptr;
          replace_ptr = (replace_ptr + 1) % Depth;
          if (replace_ptr == 0) wrap_count++;
        end
        tbl_v6[slot] = it.v6;
        tbl_hi[slot] = it.hi;
        tbl_lo[slot] = it.lo;
        tbl_time[slot] = it.has_time ? it.now : '0;
        tbl_time_ok[slot] = it.has_time;
        v.index = slot[IndexW-1:0];
        v.accepted = 1'b1;
      end
      MODE_TOUCH: begin
        if (hit >= 0) begin
          tbl_time[hit] = it.now;
          tbl_time_ok[hit] = 1'b1;
          v.found = 1'b1;
          v.index = hit[IndexW-1:0];
          v.accepted = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (hit >= 0) begin
          v.found = 1'b1;
          v.index = hit[IndexW-1:0];
          if (tbl_time_ok[hit]) begin
            gap = (tbl_time[hit] > it.now) ? tbl_time[hit] - it.now : it.now - tbl_time[hit];
            v.limited = gap <= TimeW'(threshold);
            if (v.limited) limited_count++;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic item_t mk_item(mode_e m, logic v6, logic [AddrW-1:0] hi,
                                    logic [AddrW-1:0] lo, logic [TimeW-1:0] now,
                                    logic has_time);
    item_t it;
    it.mode = m;
    it.v6 = v6;
    it.hi = hi;
    it.lo = lo;
    it.now = now;
    it.has_time = has_time;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    source_t src;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (pick < 36) it.mode = MODE_ADD;
    else if (pick < 62) it.mode = MODE_TOUCH;
    else if (pick < 96) it.mode = MODE_QUERY;
    else it.mode = MODE_RSVD;
    if (sel < 4) begin
      // Loopback keys match the lowest entry of their family.
      it.v6 = 1'($urandom_range(0, 1));
      it.hi = '0;
      it.lo = it.v6 ? 64'd1 : {32'h0, V4Loopback};
    end else if (sel < 14) begin
      it.v6 = 1'($urandom_range(0, 1));
      it.hi = {$urandom, $urandom};
      it.lo = {$urandom, $urandom};
    end else begin
      src = source_pool[$urandom_range(0, PoolSize - 1)];
      it.v6 = src.v6;
      it.hi = src.hi;
      it.lo = src.lo;
    end
    // IPv4 ignores everything but the low word, so scramble the rest.
    if (!it.v6) begin
      it.hi = {$urandom, $urandom};
      it.lo[63:32] = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) clock_now = clock_now;
    else if (pick < 55) clock_now = clock_now + TimeW'($urandom_range(1, 2000));
    else if (pick < 85) clock_now = clock_now + TimeW'($urandom_range(0, 1000000));
    else if (pick < 93) clock_now = clock_now - TimeW'($urandom_range(0, 3000));
    else clock_now = TimeW'({$urandom, $urandom});
    it.now = clock_now;
    it.has_time = $urandom_range(0, 4) != 0;
    return it;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
  endtask

  // Holds the item on the ports until taken; start stays high unless the burst ends.
  task automatic send_item(item_t it);
    logic taken;
    mode_drv <= it.mode;
    v6_drv <= it.v6;
    hi_drv <= it.hi;
    lo_drv <= it.lo;
    now_drv <= it.now;
    has_time_drv <= it.has_time;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      if (taken) begin
        expected_verdicts.push_back(predict_verdict(it));
        mode_count[it.mode]++;
      end
      @(posedge clk);
    end
    pace_sender();
  endtask

  task automatic wait_table_idle();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [ThreshW-1:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_data <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    threshold = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n && result_valid) begin
      observed = {found, entry_index, limited, accepted};
      if (expected_verdicts.size() == 0) begin
        report($sformatf("result found=%b index=%0d limited=%b accepted=%b with no item pending",
                         found, entry_index, limited, accepted));
      end else begin
        oldest = expected_verdicts.pop_front();
        results_seen++;
        if (observed !== oldest) begin
          report($sformatf("result %0d: found %b/%b index %0d/%0d limited %b/%b accepted %b/%b",
                           results_seen, found, oldest.found, entry_index, oldest.index,
                           limited, oldest.limited, accepted, oldest.accepted));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still pending",
               StallLimit, expected_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_table();
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, '0, 1'b0));
    send_item(mk_item(MODE_TOUCH, 1'b1, 64'h2001_0db8_0000_0001, 64'h5, 48'd10, 1'b1));
    send_item(mk_item(MODE_RSVD, 1'b1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_directed_matching();
    // Upper address bits are junk on IPv4 adds; they must not affect later lookups.
    send_item(mk_item(MODE_ADD, 1'b0, '1, 64'hFFFF_FFFF_0A00_0001, 48'd1000, 1'b1));
    send_item(mk_item(MODE_ADD, 1'b0, '0, 64'h0000_0000_C0A8_0001, 48'd12345, 1'b0));
    send_item(mk_item(MODE_ADD, 1'b1, '1, '1, '1, 1'b1));
    send_item(mk_item(MODE_ADD, 1'b1, 64'h2001_0db8_0000_0001, 64'h0123_4567_89AB_CDEF,
                      '0, 1'b1));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, 48'd501000, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, 64'h1234, 64'h5555_0000_0A00_0001, 48'd501001, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'hC0A8_0001, 48'd2000, 1'b0));
    send_item(mk_item(MODE_TOUCH, 1'b0, '0, 64'hC0A8_0001, 48'd2000, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'hC0A8_0001, '0, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b1, '1, '1, '0, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '1, {32'hFFFF_FFFF, V4Loopback}, 48'd900, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b1, '0, 64'd1, '1, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b1, '0, '0, 48'd7, 1'b1));
    send_item(mk_item(MODE_ADD, 1'b1, '0, 64'd1, 48'd5, 1'b1));
    send_item(mk_item(MODE_QUERY, 1'b1, 64'hFEDC_0000_0000_0000, 64'h42, 48'd6, 1'b0));
    send_item(mk_item(MODE_ADD, 1'b0, '0, {32'h0, V4Loopback}, '1, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0808_0808, 48'd3, 1'b0));
    send_item(mk_item(MODE_TOUCH, 1'b0, '0, {32'h0, V4Loopback}, 48'd77, 1'b1));
    send_item(mk_item(MODE_RSVD, 1'b0, '0, 64'h0A00_0001, 48'd78, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b1, '0, 64'h0A00_0001, 48'd79, 1'b0));
  endtask

  task automatic test_threshold_extremes();
    wait_table_idle();
    write_threshold('0);
    send_item(mk_item(MODE_TOUCH, 1'b0, '0, 64'h0A00_0001, 48'd100, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, 48'd100, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, 48'd101, 1'b0));
    wait_table_idle();
    write_threshold('1);
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, 48'h0000_0001_0000_0063, 1'b0));
    send_item(mk_item(MODE_QUERY, 1'b0, '0, 64'h0A00_0001, 48'h0000_0001_0000_0064, 1'b0));
  endtask

  task automatic test_random_phases();
    logic [ThreshW-1:0] settings[6];
    settings = '{32'd1000, 32'd0, 32'hFFFF_FFFF, $urandom, ThreshReset, 32'd1};
    for (int i = 0; i < PoolSize; i++) begin
      source_pool[i].v6 = i[0];
      source_pool[i].hi = (i < 8) ? 64'h2001_0db8_0000_0000 : {$urandom, $urandom};
      source_pool[i].lo = {$urandom, $urandom | 32'h100};
    end
    clock_now = TimeW'({$urandom, $urandom});
    foreach (settings[p]) begin
      wait_table_idle();
      write_threshold(settings[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) wait_table_idle();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_matching();
    test_threshold_extremes();
    test_random_phases();
    wait_table_idle();
    repeat (140) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_verdicts.size()));
    end
    $display("Covered %0d items (%0d add, %0d touch, %0d query, %0d unused) and %0d results.",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3], mode_count[0],
             mode_count[1], mode_count[2], mode_count[3], results_seen);
    $display("Replacement wrapped %0d times, %0d queries limited, %0d threshold writes.",
             wrap_count, limited_count, cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
